>>> design/cgl_pkg.sv
// ----------------------------------------------------------------------------
// cgl_pkg
// shared widths, register indexes and color helpers for the gradient lookup
// ----------------------------------------------------------------------------
package cgl_pkg;

  localparam int POS_W        = 16;
  localparam int CHAN_W       = 8;
  localparam int STOP_W       = 40;
  localparam int RGB565_W     = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 40;
  localparam int STOP_COUNT_W = 3;
  localparam int NUM_CHAN     = 3;
  localparam int CHAN_IDX_W   = 2;
  localparam int PROD_W       = CHAN_W + POS_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BASE  = 3'd1;

  // channel indexes
  localparam logic [CHAN_IDX_W-1:0] CH_RED   = 2'd0;
  localparam logic [CHAN_IDX_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CHAN_IDX_W-1:0] CH_BLUE  = 2'd2;

  typedef logic [CHAN_W-1:0] chan_t;

  // floor(x / 255) for x below 16320, via reciprocal and correction
  function automatic logic [5:0] cgl_div255(input logic [13:0] x);
    logic [13:0] t;
    t = x + {8'd0, x[13:8]} + 14'd1;
    return t[13:8];
  endfunction

  // 5-6-5 packing, each field channel * max / 255 truncated
  function automatic logic [RGB565_W-1:0] cgl_rgb565(input chan_t r, input chan_t g,
                                                     input chan_t b);
    logic [5:0] r5;
    logic [5:0] g6;
    logic [5:0] b5;
    r5 = cgl_div255(14'(r) * 14'd31);
    g6 = cgl_div255(14'(g) * 14'd63);
    b5 = cgl_div255(14'(b) * 14'd31);
    return {r5[4:0], g6, b5[4:0]};
  endfunction

endpackage

>>> design/cgl_if.sv
// ----------------------------------------------------------------------------
// cgl_if
// valid/ready channels of the gradient lookup: query, result and register write
// ----------------------------------------------------------------------------
interface cgl_in_if;
  import cgl_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface

interface cgl_out_if;
  import cgl_pkg::*;
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;
  logic [RGB565_W-1:0] rgb565;
  modport source (output valid, output red, output green, output blue, output rgb565,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input rgb565,
                output ready);
endinterface

interface cgl_cfg_if;
  import cgl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/cgl_div.sv
// ----------------------------------------------------------------------------
// cgl_div
// restoring divider, one quotient bit a cycle, 8-bit quotient
// ----------------------------------------------------------------------------
module cgl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cgl_pkg::PROD_W-1:0]  dividend,
  input  logic [cgl_pkg::POS_W-1:0]   divisor,
  output logic                        done,
  output logic [cgl_pkg::CHAN_W-1:0]  quotient
);
  import cgl_pkg::*;

  // dividend < 256 * divisor, so the upper part starts below the divisor
  logic                busy_r, busy_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [POS_W-1:0]    rem_r, rem_nxt;
  logic [CHAN_W-1:0]   dvd_r, dvd_nxt;
  logic [POS_W-1:0]    den_r, den_nxt;
  logic [POS_W:0]      trial;
  logic [POS_W:0]      diff;
  logic                ge;

  assign trial = {rem_r, dvd_r[CHAN_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  assign done     = busy_r && (cnt_r == 3'd7);
  assign quotient = {dvd_r[CHAN_W-2:0], ge};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      rem_nxt  = dividend[PROD_W-1:CHAN_W];
      dvd_nxt  = dividend[CHAN_W-1:0];
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
      dvd_nxt = {dvd_r[CHAN_W-2:0], ge};
      cnt_nxt = cnt_r + 3'd1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
  end

endmodule

>>> design/color_gradient_lookup_unit.sv
// ----------------------------------------------------------------------------
// color_gradient_lookup_unit
// piecewise-linear color gradient over up to MAX_STOPS stops, RGB888 + RGB565
// ----------------------------------------------------------------------------
// One query position goes in, one color comes out. The stops are scanned one
// per cycle from stop 0 upward until a stop at or above the query or the last
// stop is found; a query between two stops then has each of red, green and
// blue interpolated in turn through one shared 8x16 multiplier feeding an
// 8-step restoring divider. A finished color sits in an output register, so
// the next query is taken while the last result waits. The user must write
// registers only while the unit is idle; the unit itself does not enforce
// this; stops must be in ascending order.
module color_gradient_lookup_unit #(
  parameter int MAX_STOPS = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  cgl_cfg_if.sink   cfg_chan,
  cgl_in_if.sink    in_chan,
  cgl_out_if.source out_chan
);
  import cgl_pkg::*;

  localparam int IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  // configuration registers
  logic [STOP_COUNT_W-1:0] stop_count_r;
  logic [STOP_W-1:0]       stops_r [MAX_STOPS];

  // sequencer state
  logic [2:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [POS_W-1:0]        query_r, query_nxt;
  logic [STOP_W-1:0]       prev_r, prev_nxt;
  logic [POS_W-1:0]        num_r, num_nxt;
  logic [POS_W-1:0]        den_r, den_nxt;
  logic [CHAN_IDX_W-1:0]   chan_r, chan_nxt;
  chan_t                   a_r   [NUM_CHAN];
  chan_t                   a_nxt [NUM_CHAN];
  chan_t                   b_r   [NUM_CHAN];
  chan_t                   b_nxt [NUM_CHAN];
  chan_t                   res_r   [NUM_CHAN];
  chan_t                   res_nxt [NUM_CHAN];

  // output register
  logic                    out_valid_r, out_valid_nxt;
  chan_t                   out_red_r, out_green_r, out_blue_r;
  logic [RGB565_W-1:0]     out_rgb565_r;
  logic                    out_load;

  // scan and interpolation helpers
  logic [STOP_COUNT_W-1:0] n_eff;
  logic [STOP_W-1:0]       cur_stop;
  logic [POS_W-1:0]        cur_pos;
  logic [POS_W-1:0]        prev_pos;
  logic                    is_last;
  chan_t                   ch_a, ch_b, ch_diff;
  logic                    ch_up;
  logic [PROD_W-1:0]       product;
  logic                    div_start;
  logic                    div_done;
  chan_t                   div_q;

  // active stop count, clamped to the storage
  assign n_eff = (stop_count_r > STOP_COUNT_W'(MAX_STOPS)) ?
                 STOP_COUNT_W'(MAX_STOPS) : stop_count_r;

  assign cur_stop = stops_r[idx_r];
  assign cur_pos  = cur_stop[STOP_W-1:STOP_W-POS_W];
  assign prev_pos = prev_r[STOP_W-1:STOP_W-POS_W];
  assign is_last  = (STOP_COUNT_W'(idx_r) == (n_eff - STOP_COUNT_W'(1)));

  // shared multiplier: |next - prev| * (q - p0), registered inside the divider
  assign ch_a      = a_r[chan_r];
  assign ch_b      = b_r[chan_r];
  assign ch_up     = ch_b >= ch_a;
  assign ch_diff   = ch_up ? (ch_b - ch_a) : (ch_a - ch_b);
  assign product   = PROD_W'(ch_diff) * PROD_W'(num_r);
  assign div_start = (state_r == S_MUL);

  cgl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // handshakes
  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_load       = (state_r == S_FINISH) && (!out_valid_r || out_chan.ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
        stops_r[i] <= '0;
      end
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == REG_STOP_COUNT) begin
        stop_count_r <= cfg_chan.data[STOP_COUNT_W-1:0];
      end
      for (int i = 0; i < MAX_STOPS; i++) begin
        if (cfg_chan.index == REG_STOP_BASE + CFG_IDX_W'(i)) begin
          stops_r[i] <= cfg_chan.data[STOP_W-1:0];
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    query_nxt = query_r;
    prev_nxt  = prev_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    chan_nxt  = chan_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          query_nxt = in_chan.position;
          idx_nxt   = '0;
          if (n_eff == '0) begin
            // no stops: black
            for (int c = 0; c < NUM_CHAN; c++) begin
              res_nxt[c] = '0;
            end
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cur_pos > query_r) begin
          if (idx_r == '0) begin
            // before the first stop: clamp
            res_nxt[CH_RED]   = cur_stop[23:16];
            res_nxt[CH_GREEN] = cur_stop[15:8];
            res_nxt[CH_BLUE]  = cur_stop[7:0];
            state_nxt = S_FINISH;
          end else begin
            // bracketed by the previous stop and this one
            a_nxt[CH_RED]   = prev_r[23:16];
            a_nxt[CH_GREEN] = prev_r[15:8];
            a_nxt[CH_BLUE]  = prev_r[7:0];
            b_nxt[CH_RED]   = cur_stop[23:16];
            b_nxt[CH_GREEN] = cur_stop[15:8];
            b_nxt[CH_BLUE]  = cur_stop[7:0];
            num_nxt   = query_r - prev_pos;
            den_nxt   = cur_pos - prev_pos;
            chan_nxt  = CH_RED;
            state_nxt = S_MUL;
          end
        end else if (cur_pos == query_r || is_last) begin
          // exact hit, or past the last stop: clamp
          res_nxt[CH_RED]   = cur_stop[23:16];
          res_nxt[CH_GREEN] = cur_stop[15:8];
          res_nxt[CH_BLUE]  = cur_stop[7:0];
          state_nxt = S_FINISH;
        end else begin
          prev_nxt = cur_stop;
          idx_nxt  = idx_r + IDX_W'(1);
        end
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt[chan_r] = ch_up ? (ch_a + div_q) : (ch_a - div_q);
          if (chan_r == CH_BLUE) begin
            state_nxt = S_FINISH;
          end else begin
            chan_nxt  = chan_r + CHAN_IDX_W'(1);
            state_nxt = S_MUL;
          end
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register stays full until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r   <= idx_nxt;
    query_r <= query_nxt;
    prev_r  <= prev_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    chan_r  <= chan_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    res_r   <= res_nxt;
    if (out_load) begin
      out_red_r    <= res_r[CH_RED];
      out_green_r  <= res_r[CH_GREEN];
      out_blue_r   <= res_r[CH_BLUE];
      out_rgb565_r <= cgl_rgb565(res_r[CH_RED], res_r[CH_GREEN], res_r[CH_BLUE]);
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.red    = out_red_r;
  assign out_chan.green  = out_green_r;
  assign out_chan.blue   = out_blue_r;
  assign out_chan.rgb565 = out_rgb565_r;

endmodule

>>> tb/gradient_color_checker.sv
// ----------------------------------------------------------------------------
// gradient_color_checker
// watches the register, query and color channels of the gradient lookup,
// keeps its own copy of the stop table, predicts the color of every accepted
// query and compares each delivered color with the oldest one still owed
// ----------------------------------------------------------------------------
module gradient_color_checker #(
  parameter int MAX_STOPS = 7
) (
  input  logic clk,
  input  logic rst_n,
  cgl_cfg_if   cfg_mon,
  cgl_in_if    query_mon,
  cgl_out_if   color_mon,
  output int   mismatch_count,
  output int   colors_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import cgl_pkg::*;

  localparam int STOP_REGS = 7;

  typedef struct packed {
    chan_t               red;
    chan_t               green;
    chan_t               blue;
    logic [RGB565_W-1:0] rgb565;
  } color_t;

  logic [STOP_W-1:0]       stop_reg [STOP_REGS];
  logic [STOP_COUNT_W-1:0] stop_count_reg;
  color_t                  expected_colors [$];
  int                      fail_tally = 0;

  function automatic color_t with_rgb565(chan_t r, chan_t g, chan_t b);
    color_t c;
    c.red    = r;
    c.green  = g;
    c.blue   = b;
    c.rgb565 = {5'(int'(r) * 31 / 255), 6'(int'(g) * 63 / 255), 5'(int'(b) * 31 / 255)};
    return c;
  endfunction

  function automatic color_t stop_color(int unsigned i);
    return with_rgb565(stop_reg[i][23:16], stop_reg[i][15:8], stop_reg[i][7:0]);
  endfunction

  // color at query position q under the current stop table
  function automatic color_t gradient_color(logic [POS_W-1:0] q);
    int unsigned n, hi, p0, p1, num, den, a, b;
    chan_t       mixed [3];
    n = stop_count_reg;
    if (n > MAX_STOPS) n = MAX_STOPS;
    if (n > STOP_REGS) n = STOP_REGS;
    if (n == 0) return with_rgb565(8'h00, 8'h00, 8'h00);
    hi = n;
    for (int unsigned i = 0; i < n; i++) begin
      if (stop_reg[i][STOP_W-1 -: POS_W] > q) begin
        hi = i;
        break;
      end
      if (stop_reg[i][STOP_W-1 -: POS_W] == q) return stop_color(i);
    end
    if (hi == n) return stop_color(n - 1);
    if (hi == 0) return stop_color(0);
    // lower stop lies strictly below q, upper strictly above, so den > 0
    p0  = stop_reg[hi-1][STOP_W-1 -: POS_W];
    p1  = stop_reg[hi][STOP_W-1 -: POS_W];
    num = q - p0;
    den = p1 - p0;
    for (int c = 0; c < 3; c++) begin
      a = stop_reg[hi-1][23-8*c -: 8];
      b = stop_reg[hi][23-8*c -: 8];
      if (b >= a) mixed[c] = 8'(a + (b - a) * num / den);
      else mixed[c] = 8'(a - (a - b) * num / den);
    end
    return with_rgb565(mixed[0], mixed[1], mixed[2]);
  endfunction

  always @(posedge clk) begin
    color_t want;
    color_t got;
    if (!rst_n) begin
      stop_count_reg = '0;
      foreach (stop_reg[i]) stop_reg[i] = '0;
      expected_colors.delete();
    end else begin
      if (color_mon.valid && color_mon.ready) begin
        got = {color_mon.red, color_mon.green, color_mon.blue, color_mon.rgb565};
        if (expected_colors.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("%0t: color %02h %02h %02h / %04h with no query pending", $realtime,
                     got.red, got.green, got.blue, got.rgb565);
        end else begin
          want = expected_colors.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.rgb565 !== want.rgb565) begin
            fail_tally++;
            if (fail_tally <= 10)
              $display("%0t: color mismatch, expected %02h %02h %02h / %04h, got %02h %02h %02h / %04h",
                       $realtime, want.red, want.green, want.blue, want.rgb565,
                       got.red, got.green, got.blue, got.rgb565);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_STOP_COUNT) stop_count_reg = cfg_mon.data[STOP_COUNT_W-1:0];
        else stop_reg[cfg_mon.index - REG_STOP_BASE] = cfg_mon.data;
      end
      if (query_mon.valid && query_mon.ready)
        expected_colors.push_back(gradient_color(query_mon.position));
    end
    mismatch_count <= fail_tally;
    colors_owed    <= expected_colors.size();
  end

endmodule

>>> tb/color_gradient_lookup_unit_test.sv
// ----------------------------------------------------------------------------
// color_gradient_lookup_unit_test
// stimulus and verdict for the gradient lookup: directed stop tables and
// queries first, then random stop tables with queries clustered around the
// stops, random stalls on both channels, checked by gradient_color_checker
// ----------------------------------------------------------------------------
module color_gradient_lookup_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cgl_pkg::*;

  localparam int MAX_STOPS     = 7;
  localparam int STOP_REGS     = 7;
  localparam int RANDOM_PHASES = 20;
  localparam int PHASE_ITEMS   = 76;
  localparam int QUIET_PHASES  = 3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   quiet = 1'b0;   // set in the last phases: no idling on either side
  int   mismatch_count;
  int   colors_owed;

  // stop table the stimulus is currently aiming at
  logic [STOP_W-1:0]       grad_stop [STOP_REGS];
  logic [STOP_COUNT_W-1:0] grad_count;

  cgl_cfg_if cfg_chan ();
  cgl_in_if  in_chan ();
  cgl_out_if out_chan ();

  color_gradient_lookup_unit #(
    .MAX_STOPS (MAX_STOPS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  gradient_color_checker #(
    .MAX_STOPS (MAX_STOPS)
  ) color_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_mon        (cfg_chan),
    .query_mon      (in_chan),
    .color_mon      (out_chan),
    .mismatch_count (mismatch_count),
    .colors_owed    (colors_owed)
  );

  always #10 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  // one register write, held until the unit takes it; valid stays up
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STOP_W-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
  endtask

  // stop offering queries and wait until every owed color has come back;
  // the owed count is sampled at the falling edge, clear of the update
  task automatic settle();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (colors_owed != 0);
    @(posedge clk);
  endtask

  // write stop count and all seven stops, in shuffled order, once idle
  task automatic load_gradient();
    int order [8];
    int j;
    int t;
    settle();
    foreach (order[k]) order[k] = k;
    for (int k = 7; k > 0; k--) begin
      j        = $urandom_range(0, k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    foreach (order[k]) begin
      if (order[k] == 0) write_reg(REG_STOP_COUNT, STOP_W'(grad_count));
      else write_reg(REG_STOP_BASE + CFG_IDX_W'(order[k] - 1), grad_stop[order[k] - 1]);
    end
    cfg_chan.valid <= 1'b0;
  endtask

  // one query item, sometimes after a burst of idle cycles
  task automatic send_query(logic [POS_W-1:0] pos);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.position <= pos;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // channel level, leaning on black and full scale
  function automatic chan_t pick_level();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return chan_t'($urandom);
  endfunction

  // query position: mostly right at or next to a stop, some between stops,
  // some at the ends of the range and some anywhere
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned       n;
    int unsigned       i;
    int unsigned       r;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  up;
    n = grad_count;
    r = $urandom_range(0, 9);
    if (n == 0 || r >= 8) return POS_W'($urandom);
    if (r == 7) return $urandom_range(0, 1) ? '1 : '0;
    i = $urandom_range(0, n - 1);
    if (r < 5)
      return grad_stop[i][STOP_W-1 -: POS_W] + POS_W'($urandom_range(0, 6)) - POS_W'(3);
    if (i == n - 1) return POS_W'($urandom);
    lo = grad_stop[i][STOP_W-1 -: POS_W];
    up = grad_stop[i+1][STOP_W-1 -: POS_W];
    if (up > lo) return POS_W'($urandom_range(up, lo));
    return POS_W'($urandom);
  endfunction

  // random stop table: mostly ascending with random spacing, sometimes
  // tightly clustered (one-step divisors, repeated positions), sometimes
  // pinned to both ends of the range, now and then in no order at all
  task automatic random_gradient();
    int unsigned r;
    int unsigned span;
    int unsigned p;
    bit          shuffled;
    r = $urandom_range(0, 9);
    if (r == 0) grad_count = '0;
    else if (r == 1) grad_count = STOP_COUNT_W'(1);
    else grad_count = STOP_COUNT_W'($urandom_range(2, MAX_STOPS));
    case ($urandom_range(0, 4))
      0: begin
        span = 3;
      end
      1: begin
        span = 600;
      end
      default: begin
        span = 12000;
      end
    endcase
    shuffled = ($urandom_range(0, 7) == 0);
    p        = $urandom_range(0, 2000);
    for (int k = 0; k < STOP_REGS; k++) begin
      if (shuffled) grad_stop[k][STOP_W-1 -: POS_W] = POS_W'($urandom);
      else grad_stop[k][STOP_W-1 -: POS_W] = (p > 65535) ? '1 : POS_W'(p);
      grad_stop[k][23:0] = {pick_level(), pick_level(), pick_level()};
      p += $urandom_range(0, span);
    end
    // pin the table to both ends of the position range
    if (!shuffled && grad_count != 0 && $urandom_range(0, 2) == 0) begin
      grad_stop[0][STOP_W-1 -: POS_W]            = '0;
      grad_stop[grad_count - 1][STOP_W-1 -: POS_W] = '1;
    end
  endtask

  // result side: ready bursts and stall bursts, no stalls once quiet
  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [POS_W-1:0] probe [13];
    cfg_chan.valid   <= 1'b0;
    cfg_chan.index   <= REG_STOP_COUNT;
    cfg_chan.data    <= '0;
    in_chan.valid    <= 1'b0;
    in_chan.position <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // no stops after reset: black at both ends of the range
    send_query(16'h0000);
    send_query(16'hFFFF);

    // seven stops, rising and falling channels, a one-step segment,
    // a repeated position and a stop at the top of the range
    grad_count   = STOP_COUNT_W'(7);
    grad_stop[0] = {16'd100,   24'hFF0080};
    grad_stop[1] = {16'd1100,  24'h00FF7F};
    grad_stop[2] = {16'd1101,  24'hFFFFFF};
    grad_stop[3] = {16'd30000, 24'h000000};
    grad_stop[4] = {16'd30000, 24'h123456};
    grad_stop[5] = {16'd50000, 24'hFF00FF};
    grad_stop[6] = {16'd65535, 24'h01FE00};
    load_gradient();
    // before the first stop, exact hits, interior points, the repeated
    // position (first stop wins) and the top end
    probe = '{16'd0, 16'd99, 16'd100, 16'd101, 16'd600, 16'd1099, 16'd1100,
              16'd1101, 16'd15000, 16'd30000, 16'd40000, 16'd65534, 16'd65535};
    foreach (probe[k]) send_query(probe[k]);

    // only two stops active: past the last one clamps to stop 1
    grad_count = STOP_COUNT_W'(2);
    load_gradient();
    send_query(16'd65535);
    send_query(16'd5000);

    // stops out of order: the scan stops at the first higher stop
    grad_count   = STOP_COUNT_W'(3);
    grad_stop[0] = {16'd40000, 24'h20E0A0};
    grad_stop[1] = {16'd10000, 24'hFF0000};
    grad_stop[2] = {16'd60000, 24'h00FFFF};
    load_gradient();
    send_query(16'd5000);
    send_query(16'd20000);
    send_query(16'd50000);
    send_query(16'd65535);

    // single stop: below, at and above it all give its color
    grad_count   = STOP_COUNT_W'(1);
    grad_stop[0] = {16'h8000, 24'h8040C0};
    load_gradient();
    send_query(16'h7FFF);
    send_query(16'h8000);
    send_query(16'h8001);

    // random stop tables, each followed by a run of queries
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      quiet = (ph >= RANDOM_PHASES - QUIET_PHASES);
      random_gradient();
      load_gradient();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // in even phases, hold back mid-phase until the unit has delivered everything
        if (k == PHASE_ITEMS / 2 && ph % 2 == 0) settle();
        send_query(pick_position());
      end
    end

    // drain, then give a stray color time to show up
    settle();
    repeat (60) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && colors_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
